// File: design/mtf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtf_pkg: shared types and codes of the move-to-front list unit
// Command codes, channel payloads and the structs that run along the cell row.
// ----------------------------------------------------------------------------
package mtf_pkg;

	localparam logic [1:0] CMD_INSERT  = 2'd0;
	localparam logic [1:0] CMD_DELETE  = 2'd1;
	localparam logic [1:0] CMD_SETPAGE = 2'd2;
	localparam logic [1:0] CMD_READ    = 2'd3;

	localparam int unsigned PAGE_W = 16;
	localparam int unsigned SLOT_W = 3;
	localparam int unsigned OKEY_W = 32;

	typedef struct packed {
		logic [1:0]        command;
		logic [OKEY_W-1:0] key;
		logic [PAGE_W-1:0] page;
		logic [SLOT_W-1:0] slot;
	} cmd_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] hit_slot;
		logic              entry_valid;
		logic [OKEY_W-1:0] entry_key;
		logic [PAGE_W-1:0] entry_page;
	} rsp_t;

	// Broadcast to every cell in the cycle of a transfer.
	typedef struct packed {
		logic              en;
		logic              insert;
		logic              delete_slot;
		logic              set_page;
		logic [PAGE_W-1:0] page;
		logic [SLOT_W-1:0] slot;
	} ctl_t;

	// Running values handed from one cell to the next, slot 0 first.
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] hit_slot;
		logic              rep_valid;
		logic [OKEY_W-1:0] rep_key;
		logic [PAGE_W-1:0] rep_page;
	} chain_t;

endpackage
`default_nettype wire

// File: design/mru_move_to_front_list_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mru_move_to_front_list_unit: most-recently-used list with move to front
// A row of LIST_DEPTH cells holds (key, page, valid) entries, slot 0 newest.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  cmd     | in        | cmd_valid, cmd_ready | mtf_pkg::cmd_t
//  rsp     | out       | rsp_valid, rsp_ready | mtf_pkg::rsp_t
//
// Every command is applied to the cell row in the cycle of its transfer and
// its result is registered; one command a cycle while cmd_ready is high.
// The compare, first-match and report chains through the cells set that path.
// A result register plus one skid entry let a command transfer while a result
// waits; cmd_ready drops only when both are full. Reset empties the list.
// ----------------------------------------------------------------------------
module mru_move_to_front_list_unit #(
	parameter int unsigned LIST_DEPTH = 8,
	parameter int unsigned KEY_WIDTH  = 32
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            cmd_valid,
	output logic           cmd_ready,
	input  mtf_pkg::cmd_t  cmd,
	output logic           rsp_valid,
	input  wire            rsp_ready,
	output mtf_pkg::rsp_t  rsp
);

	mtf_pkg::ctl_t              ctl;
	mtf_pkg::chain_t            chain [LIST_DEPTH+1];
	mtf_pkg::rsp_t              rsp_new;
	mtf_pkg::rsp_t              out_q;
	mtf_pkg::rsp_t              skid_q;
	logic                       out_valid_q;
	logic                       skid_valid_q;
	logic                       xfer;
	logic [KEY_WIDTH-1:0]       new_key;
	logic [LIST_DEPTH-1:0]      cell_valid;
	logic [KEY_WIDTH-1:0]       cell_key  [LIST_DEPTH];
	logic [mtf_pkg::PAGE_W-1:0] cell_page [LIST_DEPTH];

	assign cmd_ready = !skid_valid_q;
	assign xfer      = cmd_valid && cmd_ready;
	assign new_key   = KEY_WIDTH'(cmd.key);

	assign ctl.en          = xfer;
	assign ctl.insert      = (cmd.command == mtf_pkg::CMD_INSERT);
	assign ctl.delete_slot = (cmd.command == mtf_pkg::CMD_DELETE);
	assign ctl.set_page    = (cmd.command == mtf_pkg::CMD_SETPAGE);
	assign ctl.page        = cmd.page;
	assign ctl.slot        = cmd.slot;

	assign chain[0] = '0;

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		logic                       p_valid;
		logic [KEY_WIDTH-1:0]       p_key;
		logic [mtf_pkg::PAGE_W-1:0] p_page;
		logic                       n_valid;
		logic [KEY_WIDTH-1:0]       n_key;
		logic [mtf_pkg::PAGE_W-1:0] n_page;

		// Slot 0 receives the new entry; the last slot pulls in an empty one.
		if (i == 0) begin : g_head
			assign p_valid = 1'b1;
			assign p_key   = new_key;
			assign p_page  = cmd.page;
		end else begin : g_body
			assign p_valid = cell_valid[i-1];
			assign p_key   = cell_key[i-1];
			assign p_page  = cell_page[i-1];
		end
		if (i == LIST_DEPTH - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_key   = '0;
			assign n_page  = '0;
		end else begin : g_mid
			assign n_valid = cell_valid[i+1];
			assign n_key   = cell_key[i+1];
			assign n_page  = cell_page[i+1];
		end

		mtf_cell #(
			.CELL_INDEX (i),
			.KEY_WIDTH  (KEY_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_key    (new_key),
			.prev_valid (p_valid),
			.prev_key   (p_key),
			.prev_page  (p_page),
			.next_valid (n_valid),
			.next_key   (n_key),
			.next_page  (n_page),
			.chain_in   (chain[i]),
			.chain_out  (chain[i+1]),
			.valid      (cell_valid[i]),
			.key        (cell_key[i]),
			.page       (cell_page[i])
		);
	end

	always_comb begin
		rsp_new.hit         = ctl.insert && chain[LIST_DEPTH].found;
		rsp_new.hit_slot    = ctl.insert ? chain[LIST_DEPTH].hit_slot : '0;
		rsp_new.entry_valid = chain[LIST_DEPTH].rep_valid;
		rsp_new.entry_key   = chain[LIST_DEPTH].rep_key;
		rsp_new.entry_page  = chain[LIST_DEPTH].rep_page;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || rsp_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= xfer;
			end
		end else if (xfer) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || rsp_ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (xfer) begin
				out_q <= rsp_new;
			end
		end else if (xfer) begin
			skid_q <= rsp_new;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Valid entries always form an unbroken run starting at slot 0.
	a_valid_run: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, cell_valid} + (LIST_DEPTH+1)'(1)))
		else $error("list has a hole in its valid entries");

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while result register is empty");

	a_insert_result: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && ctl.insert && !out_valid_q) |=> (rsp_valid && rsp.entry_valid))
		else $error("insert did not report a valid front entry");

	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.hit) |-> rsp.entry_valid)
		else $error("hit reported with an empty entry");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.entry_valid) |-> (rsp.entry_key == '0 && rsp.entry_page == '0))
		else $error("empty entry reported with nonzero contents");

endmodule
`default_nettype wire

// File: design/mtf_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtf_cell: one slot of the list
// Holds one entry, compares it with the incoming key, and takes its new value
// from the neighbor above (insert) or below (delete) or from the command.
// ----------------------------------------------------------------------------
module mtf_cell #(
	parameter int unsigned CELL_INDEX = 0,
	parameter int unsigned KEY_WIDTH  = 32
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  mtf_pkg::ctl_t                 ctl,
	input  wire  [KEY_WIDTH-1:0]          new_key,
	input  wire                           prev_valid,
	input  wire  [KEY_WIDTH-1:0]          prev_key,
	input  wire  [mtf_pkg::PAGE_W-1:0]    prev_page,
	input  wire                           next_valid,
	input  wire  [KEY_WIDTH-1:0]          next_key,
	input  wire  [mtf_pkg::PAGE_W-1:0]    next_page,
	input  mtf_pkg::chain_t               chain_in,
	output mtf_pkg::chain_t               chain_out,
	output logic                          valid,
	output logic [KEY_WIDTH-1:0]          key,
	output logic [mtf_pkg::PAGE_W-1:0]    page
);

	localparam bit IN_SLOT_RANGE = (CELL_INDEX < (1 << mtf_pkg::SLOT_W));
	localparam logic [mtf_pkg::SLOT_W-1:0] IDX = mtf_pkg::SLOT_W'(CELL_INDEX);

	logic                       valid_q;
	logic [KEY_WIDTH-1:0]       key_q;
	logic [mtf_pkg::PAGE_W-1:0] page_q;
	logic                       valid_d;
	logic [KEY_WIDTH-1:0]       key_d;
	logic [mtf_pkg::PAGE_W-1:0] page_d;
	logic                       match;
	logic                       is_slot;
	logic                       at_or_past;
	logic                       rep_sel;

	assign match      = valid_q && (key_q == new_key);
	assign is_slot    = IN_SLOT_RANGE && (ctl.slot == IDX);
	assign at_or_past = !IN_SLOT_RANGE || (IDX >= ctl.slot);
	assign rep_sel    = ctl.insert ? (CELL_INDEX == 0) : is_slot;

	always_comb begin
		valid_d = valid_q;
		key_d   = key_q;
		page_d  = page_q;
		// Cells above the first match (and the match itself) move down one slot.
		if (ctl.en && ctl.insert && !chain_in.found) begin
			valid_d = prev_valid;
			key_d   = prev_key;
			page_d  = prev_page;
		end else if (ctl.en && ctl.delete_slot && at_or_past) begin
			valid_d = next_valid;
			key_d   = next_key;
			page_d  = next_page;
		end else if (ctl.en && ctl.set_page && is_slot && valid_q) begin
			page_d = ctl.page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			key_q   <= '0;
			page_q  <= '0;
		end else begin
			valid_q <= valid_d;
			key_q   <= key_d;
			page_q  <= page_d;
		end
	end

	always_comb begin
		chain_out.found    = chain_in.found || match;
		chain_out.hit_slot = chain_in.hit_slot;
		if (match && !chain_in.found) begin
			chain_out.hit_slot = chain_in.hit_slot | IDX;
		end
		chain_out.rep_valid = chain_in.rep_valid;
		chain_out.rep_key   = chain_in.rep_key;
		chain_out.rep_page  = chain_in.rep_page;
		// The reported slot shows its value as it stands after the command.
		if (rep_sel && valid_d) begin
			chain_out.rep_valid = 1'b1;
			chain_out.rep_key   = chain_in.rep_key | mtf_pkg::OKEY_W'(key_d);
			chain_out.rep_page  = chain_in.rep_page | page_d;
		end
	end

	assign valid = valid_q;
	assign key   = key_q;
	assign page  = page_q;

endmodule
`default_nettype wire
